[rtl/core/qse_pkg.sv]
`default_nettype none

package qse_pkg;

    // Capacity of the element store and derived index widths.
    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int VAL_W     = 32;

    // Pending-range stack: one entry holds a low and a high index.
    localparam int STK_DEPTH = 64;
    localparam int STK_AW    = $clog2(STK_DEPTH);
    localparam int STK_W     = 2 * IDX_W;

    // One access to the element store: one write and one read address per cycle.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } store_req_t;

    // Signed ordering of two stored elements.
    function automatic logic key_less(input logic signed [VAL_W-1:0] a,
                                      input logic signed [VAL_W-1:0] b);
        return a < b;
    endfunction

endpackage

`default_nettype wire

[rtl/core/qse_ram.sv]
`default_nettype none

module qse_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/qse_sorter.sv]
`default_nettype none

module qse_sorter
    import qse_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic [VAL_W-1:0] store_rdata,
    output store_req_t            store_req,
    output logic                  done
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_INIT     = 12'b0000_0000_0010,
        S_POP      = 12'b0000_0000_0100,
        S_POP_DATA = 12'b0000_0000_1000,
        S_PIVOT    = 12'b0000_0001_0000,
        S_SCAN     = 12'b0000_0010_0000,
        S_SWAP_A   = 12'b0000_0100_0000,
        S_SWAP_B   = 12'b0000_1000_0000,
        S_FINAL    = 12'b0001_0000_0000,
        S_FIN_A    = 12'b0010_0000_0000,
        S_FIN_B    = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } sort_state_t;

    sort_state_t state_reg, state_next;
    logic [STK_AW:0]  sp_reg, sp_next;
    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] place_reg, place_next;
    logic [VAL_W-1:0] pivot_reg, pivot_next;
    logic [VAL_W-1:0] hold_reg, hold_next;

    logic              stk_we;
    logic [STK_AW-1:0] stk_waddr;
    logic [STK_W-1:0]  stk_wdata;
    logic [STK_AW-1:0] stk_raddr;
    logic [STK_W-1:0]  stk_rdata;

    logic [IDX_W-1:0] pop_lo;
    logic [IDX_W-1:0] pop_hi;
    logic             scan_end;

    qse_ram #(
        .WIDTH (STK_W),
        .DEPTH (STK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign pop_lo   = stk_rdata[STK_W-1:IDX_W];
    assign pop_hi   = stk_rdata[IDX_W-1:0];
    assign scan_end = (CNT_W'(j_reg) + CNT_W'(1)) == CNT_W'(hi_reg);
    assign done     = (state_reg == S_DONE);

    always_comb begin
        state_next = state_reg;
        sp_next    = sp_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        j_next     = j_reg;
        place_next = place_reg;
        pivot_next = pivot_reg;
        hold_next  = hold_reg;
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[STK_AW-1:0];
        stk_wdata  = {lo_reg, hi_reg};
        stk_raddr  = sp_reg[STK_AW-1:0] - STK_AW'(1);
        store_req  = '{we: 1'b0, waddr: place_reg, wdata: hold_reg, raddr: j_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = (count >= CNT_W'(2)) ? S_INIT : S_DONE;
                end
            end
            S_INIT: begin
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = {IDX_W'(0), IDX_W'(count - CNT_W'(1))};
                sp_next    = (STK_AW+1)'(1);
                state_next = S_POP;
            end
            S_POP: begin
                if (sp_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    sp_next    = sp_reg - (STK_AW+1)'(1);
                    state_next = S_POP_DATA;
                end
            end
            S_POP_DATA: begin
                lo_next = pop_lo;
                hi_next = pop_hi;
                store_req.raddr = pop_hi;
                state_next = (pop_lo >= pop_hi) ? S_POP : S_PIVOT;
            end
            S_PIVOT: begin
                pivot_next      = store_rdata;
                place_next      = lo_reg;
                j_next          = lo_reg;
                store_req.raddr = lo_reg;
                state_next      = S_SCAN;
            end
            S_SCAN: begin
                // Read data holds the element at j.
                if (key_less(store_rdata, pivot_reg)) begin
                    hold_next       = store_rdata;
                    store_req.raddr = place_reg;
                    state_next      = S_SWAP_A;
                end else begin
                    j_next          = j_reg + IDX_W'(1);
                    store_req.raddr = j_reg + IDX_W'(1);
                    state_next      = scan_end ? S_FINAL : S_SCAN;
                end
            end
            S_SWAP_A: begin
                store_req.we    = 1'b1;
                store_req.waddr = place_reg;
                store_req.wdata = hold_reg;
                hold_next       = store_rdata;
                state_next      = S_SWAP_B;
            end
            S_SWAP_B: begin
                store_req.we    = 1'b1;
                store_req.waddr = j_reg;
                store_req.wdata = hold_reg;
                store_req.raddr = j_reg + IDX_W'(1);
                place_next      = place_reg + IDX_W'(1);
                j_next          = j_reg + IDX_W'(1);
                state_next      = scan_end ? S_FINAL : S_SCAN;
            end
            S_FINAL: begin
                store_req.raddr = place_reg;
                state_next      = S_FIN_A;
            end
            S_FIN_A: begin
                store_req.we    = 1'b1;
                store_req.waddr = place_reg;
                store_req.wdata = pivot_reg;
                hold_next       = store_rdata;
                // Left part [lo, place-1] when it holds two or more elements.
                if (CNT_W'(place_reg) > CNT_W'(lo_reg) + CNT_W'(1)) begin
                    stk_we    = 1'b1;
                    stk_wdata = {lo_reg, place_reg - IDX_W'(1)};
                    sp_next   = sp_reg + (STK_AW+1)'(1);
                end
                state_next = S_FIN_B;
            end
            S_FIN_B: begin
                store_req.we    = 1'b1;
                store_req.waddr = hi_reg;
                store_req.wdata = hold_reg;
                // Right part [place+1, hi] when it holds two or more elements.
                if (CNT_W'(place_reg) + CNT_W'(1) < CNT_W'(hi_reg)) begin
                    stk_we    = 1'b1;
                    stk_wdata = {place_reg + IDX_W'(1), hi_reg};
                    sp_next   = sp_reg + (STK_AW+1)'(1);
                end
                state_next = S_POP;
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        j_reg     <= j_next;
        place_reg <= place_next;
        pivot_reg <= pivot_next;
        hold_reg  <= hold_next;
    end

endmodule

`default_nettype wire

[rtl/core/quick_sort_engine_unit.sv]
`default_nettype none

// Quicksort engine for up to 64 signed 32-bit values. Values arrive one per
// input transaction and are written into a local store; the transaction with
// last set closes the set. Values beyond the 64th, including a final one, are
// dropped, and every result of that run then reports truncated. Once the set
// is closed the block sorts it in place in ascending order with a Lomuto
// partition (rightmost element as pivot) and a stack of pending subranges in
// a small RAM, then returns every value as one output transaction in order,
// with end_of_run on the final one. The input takes one transaction per cycle
// while the set is collected. The sort runs on a single comparator and a
// one-read, one-write store, so its time is set by that memory port: a pivot
// comparison that does not swap passes through S_SCAN alone, one that swaps
// adds S_SWAP_A and S_SWAP_B, and each partitioned subrange adds S_POP,
// S_POP_DATA, S_PIVOT, S_FINAL, S_FIN_A and S_FIN_B. Already ascending input
// is a slow case. Each result is read, loaded and offered in turn, and the
// next read waits until the result has been taken. The input is not ready
// from the closing transaction until the last result has been taken.
module quick_sort_engine_unit
    import qse_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [VAL_W-1:0] s_value,
    input  wire logic                    s_last,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [VAL_W-1:0]      m_sorted_value,
    output logic                         m_end_of_run,
    output logic                         m_truncated
);

    // Top-level sequencer: collect, hand the store to the sorter, emit.
    typedef enum logic [4:0] {
        T_COLLECT = 5'b00001,
        T_SORT    = 5'b00010,
        T_EMIT_RD = 5'b00100,
        T_EMIT_LD = 5'b01000,
        T_EMIT_OUT = 5'b10000
    } top_state_t;

    top_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] out_value_reg, out_value_next;
    logic             out_end_reg, out_end_next;

    store_req_t       top_req;
    store_req_t       sort_req;
    store_req_t       store_req;
    logic [VAL_W-1:0] store_rdata;
    logic             sort_done;

    logic s_accept;
    logic m_accept;
    logic store_full;
    logic emit_last;

    assign s_ready    = (state_reg == T_COLLECT);
    assign s_accept   = s_valid && s_ready;
    assign m_accept   = m_valid_reg && m_ready;
    assign store_full = (count_reg == CNT_W'(MAX_ITEMS));
    assign emit_last  = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;

    // The sorter owns the store while it runs; otherwise the store takes
    // writes from the input side and reads for the output side.
    assign store_req = (state_reg == T_SORT) ? sort_req : top_req;

    qse_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .aclk  (aclk),
        .we    (store_req.we),
        .waddr (store_req.waddr),
        .wdata (store_req.wdata),
        .raddr (store_req.raddr),
        .rdata (store_rdata)
    );

    qse_sorter u_sorter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (state_reg == T_SORT),
        .count       (count_reg),
        .store_rdata (store_rdata),
        .store_req   (sort_req),
        .done        (sort_done)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        k_next         = k_reg;
        m_valid_next   = m_valid_reg;
        out_value_next = out_value_reg;
        out_end_next   = out_end_reg;
        top_req = '{we: 1'b0, waddr: count_reg[IDX_W-1:0], wdata: s_value, raddr: k_reg};

        unique case (state_reg)
            T_COLLECT: begin
                if (s_accept) begin
                    // A value that finds the store full is dropped.
                    if (store_full) begin
                        overflow_next = 1'b1;
                    end else begin
                        top_req.we = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_last) begin
                        state_next = T_SORT;
                    end
                end
            end
            T_SORT: begin
                if (sort_done) begin
                    k_next     = '0;
                    state_next = T_EMIT_RD;
                end
            end
            T_EMIT_RD: begin
                state_next = T_EMIT_LD;
            end
            T_EMIT_LD: begin
                out_value_next = store_rdata;
                out_end_next   = emit_last;
                m_valid_next   = 1'b1;
                state_next     = T_EMIT_OUT;
            end
            T_EMIT_OUT: begin
                if (m_accept) begin
                    m_valid_next = 1'b0;
                    if (out_end_reg) begin
                        // Run complete: the block is ready for a new set.
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = T_COLLECT;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = T_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = T_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_COLLECT;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
        k_reg         <= k_next;
        out_value_reg <= out_value_next;
        out_end_reg   <= out_end_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = out_value_reg;
    assign m_end_of_run   = out_end_reg;
    // The overflow flag holds for the whole emission and clears after it.
    assign m_truncated    = overflow_reg;

endmodule

`default_nettype wire

[rtl/core/qse_checker.sv]
`default_nettype none

module qse_checker
    import qse_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_ready,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic signed [VAL_W-1:0] m_sorted_value,
    input wire logic                    m_end_of_run,
    input wire logic                    m_truncated
);

    logic             in_run_reg;
    logic [VAL_W-1:0] prev_value_reg;
    logic             prev_trunc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            in_run_reg <= !m_end_of_run;
        end
        if (m_valid && m_ready) begin
            prev_value_reg <= m_sorted_value;
            prev_trunc_reg <= m_truncated;
        end
    end

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sorted_value))
        else $error("result changed while stalled");

    // No new input while a result of the current run is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid || in_run_reg) |-> !s_ready)
        else $error("input taken during emission");

    // Results of one run come out in ascending order.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && in_run_reg |-> $signed(prev_value_reg) <= m_sorted_value)
        else $error("results out of order");

    // The truncated flag is the same on every result of a run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && in_run_reg |-> m_truncated == prev_trunc_reg)
        else $error("truncated flag changed within a run");

    // Nothing is offered right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind quick_sort_engine_unit qse_checker u_qse_checker (.*);

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
    import qse_pkg::*;

    // The worst correct run is dominated by ordered sets of full capacity, which are
    // the slow case for the sort. With the output stalls, the long hold, and about
    // 370 input transactions with random gaps, a run stays well below this limit.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int ITEM_BUDGET  = 370;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    // These are the content patterns for a set. The ordered patterns are the slow
    // case for a Lomuto partition that uses the rightmost element as the pivot.
    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_ASCENDING,
        FILL_DESCENDING
    } fill_style_t;

    // This is one sorted element as it should leave the block.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    end_of_run;
        logic                    truncated;
    } sorted_result_t;

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [VAL_W-1:0] s_value = '0;
    logic                    s_last  = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [VAL_W-1:0] m_sorted_value;
    logic                    m_end_of_run;
    logic                    m_truncated;

    // The open set is kept in ascending order as its values arrive. A stable
    // sort and a quicksort give the same output, because equal keys cannot be
    // told apart.
    logic signed [VAL_W-1:0] set_in_order[$];
    logic                    set_dropped = 1'b0;
    sorted_result_t          expected_sorted[$];

    int error_count     = 0;
    int items_sent      = 0;
    int holds_requested = 0;
    int holds_served    = 0;
    bit idling          = 1'b1;

    quick_sort_engine_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_end_of_run   (m_end_of_run),
        .m_truncated    (m_truncated)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // The idle stretches are zero whenever idling is switched off for a phase.
    function automatic int pick_gap();
        return idling ? int'($urandom_range(0, 5)) : 0;
    endfunction

    // This updates the expected state for one accepted input transaction. A value
    // that finds the store full is dropped, and that set is then marked truncated.
    // The value marked last closes the set. It releases one expected result per
    // stored value, and it clears the set for the next run.
    function automatic void absorb_value(input logic signed [VAL_W-1:0] v, input logic last);
        int             pos;
        sorted_result_t r;
        if (set_in_order.size() < MAX_ITEMS) begin
            pos = 0;
            while (pos < set_in_order.size() && set_in_order[pos] <= v)
                pos++;
            set_in_order.insert(pos, v);
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            foreach (set_in_order[k]) begin
                r.value      = set_in_order[k];
                r.end_of_run = (k == set_in_order.size() - 1);
                r.truncated  = set_dropped;
                expected_sorted.push_back(r);
            end
            set_in_order.delete();
            set_dropped = 1'b0;
        end
    endfunction

    // Both channels are observed at the rising edge. The result is checked first,
    // and then the input transaction updates the prediction. The block does not
    // take input while it is still emitting, so this order never matters.
    always @(posedge aclk) begin : monitor
        sorted_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_sorted.size() == 0) begin
                    $error("unexpected result transaction: sorted_value %0d", m_sorted_value);
                    error_count++;
                end else begin
                    want = expected_sorted.pop_front();
                    if (m_sorted_value !== want.value) begin
                        $error("sorted_value: expected %0d, actual %0d",
                               want.value, m_sorted_value);
                        error_count++;
                    end
                    if (m_end_of_run !== want.end_of_run) begin
                        $error("end_of_run: expected %0b, actual %0b",
                               want.end_of_run, m_end_of_run);
                        error_count++;
                    end
                    if (m_truncated !== want.truncated) begin
                        $error("truncated: expected %0b, actual %0b",
                               want.truncated, m_truncated);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                absorb_value(s_value, s_last);
        end
    end

    // The result side draws a stall before each result transaction. When a test
    // asks for a long hold, the stall is taken from LONG_HOLD instead. That
    // stall reaches the input side, because the block keeps s_ready low until the
    // whole run has been taken.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (holds_served != holds_requested) begin
                stall = LONG_HOLD;
                holds_served++;
            end else begin
                stall = pick_gap();
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // This sends one input transaction. It is entered and left at a falling edge.
    // Valid stays high from one transaction to the next when no gap is drawn.
    task automatic send_item(input logic signed [VAL_W-1:0] v, input logic last);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_value <= v;
        s_last  <= last;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
        @(negedge aclk);
    endtask

    // This sends a whole set with last on its final value. A count above
    // MAX_ITEMS overflows the store, and the closing value is then dropped too.
    task automatic send_set(input int count, input fill_style_t style);
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] v;
        int                      step;
        base = $signed($urandom) >>> 8;
        step = $urandom_range(1, 1000);
        for (int i = 0; i < count; i++) begin
            case (style)
                FILL_RANDOM:     v = $urandom;
                FILL_NARROW:     v = $signed(VAL_W'($urandom_range(0, 6))) - 3;
                FILL_ASCENDING:  v = base + i * step;
                default:         v = base - i * step;
            endcase
            send_item(v, i == count - 1);
        end
    endtask

    // This covers the extreme values, a single-element set, a set of equal keys,
    // and a two-element set that needs one swap.
    task automatic test_directed_values();
        send_item(VAL_MIN, 1'b1);

        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(5, 1'b1);

        repeat (3) send_item(42, 1'b0);
        send_item(42, 1'b1);

        send_item(9, 1'b0);
        send_item(-9, 1'b1);
    endtask

    // This fills the store exactly, and then overflows it in two ways. In the
    // first overflow, the closing value is the 65th and is dropped. In the second,
    // extra values come before the dropped close.
    task automatic test_capacity();
        idling = 1'b0;
        send_set(MAX_ITEMS, FILL_ASCENDING);
        send_set(MAX_ITEMS + 1, FILL_DESCENDING);
        idling = 1'b1;
        send_set(MAX_ITEMS + 3, FILL_RANDOM);
    endtask

    // This holds the output side in the middle of a run while the next set is
    // already being offered, so that the block has to stall its input.
    task automatic test_output_hold();
        holds_requested++;
        send_set(6, FILL_RANDOM);
        send_set(5, FILL_NARROW);
    endtask

    // Most of these sets are small. A few are large or overflow the store, and
    // some are ordered so that the sort sees its deep cases. Idling is switched
    // off for some sets so that back-to-back stretches occur too.
    task automatic test_random_sets();
        int pick;
        int count;
        while (items_sent < ITEM_BUDGET) begin
            idling = ($urandom_range(0, 3) != 0);
            pick   = $urandom_range(0, 99);
            if (pick < 70)
                count = $urandom_range(1, 12);
            else if (pick < 90)
                count = $urandom_range(13, 40);
            else
                count = $urandom_range(41, MAX_ITEMS + 2);
            send_set(count, fill_style_t'($urandom_range(0, 3)));
        end
        idling = 1'b1;
    endtask

    initial begin : stimulus
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_values();
        test_capacity();
        test_output_hold();
        test_random_sets();
        s_valid <= 1'b0;

        // All of the stimulus has been taken. The bench waits for the last
        // expected result, then watches a while longer for stray output.
        wait (expected_sorted.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[quick_sort_engine_unit.f]
rtl/core/qse_pkg.sv
rtl/core/qse_ram.sv
rtl/core/qse_sorter.sv
rtl/core/quick_sort_engine_unit.sv
rtl/core/qse_checker.sv
bench/tb.sv
